@@ hdl/hxp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the XOR test-pattern pixel generator.
// Holds the shared constants, the hue sector type and the divide-by-255 helper.
// It depends on nothing else.
package hxp_pkg;

    localparam int COORD_BITS = 12;
    localparam int N_STAGES   = 9;

    localparam logic [31:0] DIV3_MUL    = 32'hAAAA_AAAB;
    localparam int          DIV3_SHIFT  = 33;
    localparam logic [29:0] MOD45_MUL   = 30'd763549742;
    localparam int          MOD45_SHIFT = 35;
    localparam logic [16:0] DIV255_MUL  = 17'd65794;

    localparam logic [7:0] SAT_RESET = 8'd200;
    localparam logic [7:0] CH_MAX    = 8'd255;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector    sector;
        logic [7:0] frac;
        logic [7:0] val;
    } t_hue_item;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(DIV255_MUL);
        return p[31:24];
    endfunction

endpackage

@@ hdl/hxp_flow.sv @@
`timescale 1ns / 1ps
// Valid bits and per-stage load enables of the pixel pipeline.
// Uses hxp_pkg for the stage count; empty stages fill even while the output is held.
module hxp_flow (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_stall,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [hxp_pkg::N_STAGES-1:0]  o_en
);
    import hxp_pkg::*;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] en;

    always_comb begin
        en[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < N_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en    = en;
    assign o_stall = !en[0];
    assign o_valid = r_vld[N_STAGES-1];

endmodule

@@ hdl/hxp_hue_pipe.sv @@
`timescale 1ns / 1ps
// First five pipeline stages: XOR pattern, divide by 3, frame offset and hue modulo 360.
// Ends with the hue sector and its fraction; uses hxp_pkg.
module hxp_hue_pipe (
    input  logic                              i_clk,
    input  logic [4:0]                        i_en,
    input  logic [hxp_pkg::COORD_BITS-1:0]    i_pixel_col,
    input  logic [hxp_pkg::COORD_BITS-1:0]    i_pixel_row,
    input  logic [31:0]                       i_frame_number,
    output hxp_pkg::t_hue_item                o_item
);
    import hxp_pkg::*;

    localparam int PAD = 32 - COORD_BITS;

    logic [31:0] col32, row32, mix_a, mix_b, n1_sum;
    logic [7:0]  n1_val;
    logic [31:0] r1_sum, r1_frame;
    logic [7:0]  r1_val;

    logic [63:0] prod3;
    logic [30:0] r2_avg;
    logic [31:0] r2_frame;
    logic [7:0]  r2_val;

    logic [31:0] avg2, scaled;
    logic [28:0] r3_y;
    logic [2:0]  r3_xlo;
    logic [7:0]  r3_val;

    logic [58:0] prod45;
    logic [5:0]  r4_q, r4_y;
    logic [2:0]  r4_xlo;
    logic [7:0]  r4_val;

    logic [5:0]  q45, r45, rem;
    logic [8:0]  hue, base;
    logic [9:0]  frac17;
    t_sector     sector;
    t_hue_item   r5_item;

    assign col32  = {{PAD{1'b0}}, i_pixel_col};
    assign row32  = {{PAD{1'b0}}, i_pixel_row};
    assign mix_a  = col32 ^ row32;
    assign mix_b  = (col32 + i_frame_number) ^ (row32 + i_frame_number);
    assign n1_sum = mix_a + mix_b + (mix_a >> 1) + (mix_b >> 1);
    assign n1_val = (i_frame_number < 32'(CH_MAX)) ? i_frame_number[7:0] : CH_MAX;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sum   <= n1_sum;
            r1_frame <= i_frame_number;
            r1_val   <= n1_val;
        end
    end

    assign prod3 = 64'(r1_sum) * 64'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_avg   <= prod3[63:DIV3_SHIFT];
            r2_frame <= r1_frame;
            r2_val   <= r1_val;
        end
    end

    assign avg2   = {1'b0, r2_avg} + r2_frame;
    assign scaled = avg2 + {avg2[30:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_y   <= scaled[31:3];
            r3_xlo <= scaled[2:0];
            r3_val <= r2_val;
        end
    end

    assign prod45 = 59'(r3_y) * 59'(MOD45_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_q   <= prod45[MOD45_SHIFT+5:MOD45_SHIFT];
            r4_y   <= r3_y[5:0];
            r4_xlo <= r3_xlo;
            r4_val <= r3_val;
        end
    end

    assign q45    = {r4_q[0], 5'b0} + {r4_q[2:0], 3'b0} + {r4_q[3:0], 2'b0} + r4_q;
    assign r45    = r4_y - q45;
    assign hue    = {r45, r4_xlo};

    always_comb begin
        if (hue >= 9'd300) begin
            sector = SEC_MR;
            base   = 9'd300;
        end else if (hue >= 9'd240) begin
            sector = SEC_BM;
            base   = 9'd240;
        end else if (hue >= 9'd180) begin
            sector = SEC_CB;
            base   = 9'd180;
        end else if (hue >= 9'd120) begin
            sector = SEC_GC;
            base   = 9'd120;
        end else if (hue >= 9'd60) begin
            sector = SEC_YG;
            base   = 9'd60;
        end else begin
            sector = SEC_RY;
            base   = 9'd0;
        end
    end

    assign rem    = 6'(hue - base);
    assign frac17 = {rem, 4'b0} + 10'(rem);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_item.sector <= sector;
            r5_item.frac   <= frac17[9:2];
            r5_item.val    <= r4_val;
        end
    end

    assign o_item = r5_item;

endmodule

@@ hdl/hxp_rgb_pipe.sv @@
`timescale 1ns / 1ps
// Last four pipeline stages: integer HSV to RGB over six hue sectors.
// Takes the sector item from hxp_hue_pipe and the saturation; uses hxp_pkg.
module hxp_rgb_pipe (
    input  logic                 i_clk,
    input  logic [3:0]           i_en,
    input  hxp_pkg::t_hue_item   i_item,
    input  logic [7:0]           i_sat,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);
    import hxp_pkg::*;

    logic [15:0] r6_lo_p, r6_sf_p, r6_sr_p;
    t_sector     r6_sector;
    logic [7:0]  r6_val;

    logic [7:0]  r7_lo, r7_sf, r7_sr, r7_val;
    t_sector     r7_sector;

    logic [15:0] r8_fall_p, r8_rise_p;
    logic [7:0]  r8_lo, r8_val;
    t_sector     r8_sector;

    logic [7:0]  fall, rise;
    logic [7:0]  n_red, n_green, n_blue;
    logic [7:0]  r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r6_lo_p   <= 16'(i_item.val) * 16'(CH_MAX - i_sat);
            r6_sf_p   <= 16'(i_sat) * 16'(i_item.frac);
            r6_sr_p   <= 16'(i_sat) * 16'(CH_MAX - i_item.frac);
            r6_sector <= i_item.sector;
            r6_val    <= i_item.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r7_lo     <= div255(r6_lo_p);
            r7_sf     <= div255(r6_sf_p);
            r7_sr     <= div255(r6_sr_p);
            r7_sector <= r6_sector;
            r7_val    <= r6_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r8_fall_p <= 16'(r7_val) * 16'(CH_MAX - r7_sf);
            r8_rise_p <= 16'(r7_val) * 16'(CH_MAX - r7_sr);
            r8_lo     <= r7_lo;
            r8_val    <= r7_val;
            r8_sector <= r7_sector;
        end
    end

    assign fall = div255(r8_fall_p);
    assign rise = div255(r8_rise_p);

    always_comb begin
        unique case (r8_sector)
            SEC_RY: begin
                n_red = r8_val; n_green = rise;   n_blue = r8_lo;
            end
            SEC_YG: begin
                n_red = fall;   n_green = r8_val; n_blue = r8_lo;
            end
            SEC_GC: begin
                n_red = r8_lo;  n_green = r8_val; n_blue = rise;
            end
            SEC_CB: begin
                n_red = r8_lo;  n_green = fall;   n_blue = r8_val;
            end
            SEC_BM: begin
                n_red = rise;   n_green = r8_lo;  n_blue = r8_val;
            end
            default: begin
                n_red = r8_val; n_green = r8_lo;  n_blue = fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ hdl/hsv_xor_test_pattern_pixel_core.sv @@
`timescale 1ns / 1ps
// XOR test-pattern pixel generator, top level.
// Instantiates hxp_flow, hxp_hue_pipe and hxp_rgb_pipe and holds the saturation register.
//
// Usage:
// The input channel takes one request per cycle: pixel column, row and frame
// counter, qualified by i_valid and held off by o_stall. The output channel
// presents one RGB pixel per request on o_valid, and the receiver holds it with
// i_stall. Pixels leave in the order their requests arrived.
// A request passes through every pipeline stage, each a register, and its pixel
// appears on o_valid once it reaches the last stage; a stall can hold it on the way.
// The multiply-by-reciprocal stages and the two scaling multiply stages set the
// pipeline depth. Throughput is one pixel per cycle while i_stall stays low.
// When the receiver stalls, the output register holds its pixel and empty
// stages behind it keep filling; o_stall rises only once every stage is full.
// The saturation register is written through i_cfg_valid and i_cfg_data and
// o_cfg_ready is always high; write it only while the pipeline is empty.
// Synchronous reset empties the pipeline and sets the saturation to 200.
module hsv_xor_test_pattern_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [hxp_pkg::COORD_BITS-1:0]    i_pixel_col,
    input  logic [hxp_pkg::COORD_BITS-1:0]    i_pixel_row,
    input  logic [31:0]                       i_frame_number,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_data
);
    import hxp_pkg::*;

    logic [N_STAGES-1:0] en;
    logic [7:0]          r_sat;
    t_hue_item           hue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= SAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sat <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    hxp_flow u_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_en    (en)
    );

    hxp_hue_pipe u_hue (
        .i_clk          (i_clk),
        .i_en           (en[4:0]),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_frame_number (i_frame_number),
        .o_item         (hue_item)
    );

    hxp_rgb_pipe u_rgb (
        .i_clk   (i_clk),
        .i_en    (en[8:5]),
        .i_item  (hue_item),
        .i_sat   (r_sat),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

@@ hdl/hxp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the pixel generator and the bind that attaches them.
// Depends only on the ports of hsv_xor_test_pattern_pixel_core.
module hxp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_stall,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [7:0]                        o_red,
    input  logic [7:0]                        o_green,
    input  logic [7:0]                        o_blue,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue))
        else $error("stalled pixel changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output can move");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind hsv_xor_test_pattern_pixel_core hxp_checker u_hxp_checker (.*);

@@ tb/hsv_xor_test_pattern_pixel_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsv_xor_test_pattern_pixel_core, with its own pixel predictor.
// It depends on hxp_pkg and on the core; directed requests run first, then random ones under varied traffic.
module hsv_xor_test_pattern_pixel_core_test;
    import hxp_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 420;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [COORD_BITS-1:0] i_pixel_col;
    logic [COORD_BITS-1:0] i_pixel_row;
    logic [31:0]           i_frame_number;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [7:0]            i_cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    hsv_xor_test_pattern_pixel_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_frame_number (i_frame_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    function automatic logic [31:0] scale_by(input logic [31:0] a, input logic [31:0] b);
        return (a * b) / 32'd255;
    endfunction

    function automatic rgb_pixel_t pattern_pixel(input logic [COORD_BITS-1:0] col,
                                                 input logic [COORD_BITS-1:0] row,
                                                 input logic [31:0] frame,
                                                 input logic [7:0] sat);
        logic [31:0] col_w, row_w, mix_a, mix_b, avg, tri_avg, hue, val;
        logic [31:0] sat_w, region, frac, lo, fall, rise;
        t_sector     sector;
        rgb_pixel_t  px;
        col_w   = 32'(col);
        row_w   = 32'(row);
        sat_w   = 32'(sat);
        mix_a   = col_w ^ row_w;
        mix_b   = (col_w + frame) ^ (row_w + frame);
        avg     = (mix_a + mix_b + (mix_a >> 1) + (mix_b >> 1)) / 32'd3;
        avg     = avg + frame;
        tri_avg = avg * 32'd3;
        hue     = tri_avg % 32'd360;
        val     = (frame < 32'd255) ? frame : 32'd255;
        region  = hue / 32'd60;
        sector  = t_sector'(region[2:0]);
        frac    = ((hue - region * 32'd60) * 32'd255) / 32'd60;
        lo      = scale_by(val, 32'd255 - sat_w);
        fall    = scale_by(val, 32'd255 - scale_by(sat_w, frac));
        rise    = scale_by(val, 32'd255 - scale_by(sat_w, 32'd255 - frac));
        case (sector)
            SEC_RY: px = '{val[7:0], rise[7:0], lo[7:0]};
            SEC_YG: px = '{fall[7:0], val[7:0], lo[7:0]};
            SEC_GC: px = '{lo[7:0], val[7:0], rise[7:0]};
            SEC_CB: px = '{lo[7:0], fall[7:0], val[7:0]};
            SEC_BM: px = '{rise[7:0], lo[7:0], val[7:0]};
            default: px = '{val[7:0], lo[7:0], fall[7:0]};
        endcase
        return px;
    endfunction

    class pixel_tracker;
        rgb_pixel_t  awaited_pixels[$];
        logic [7:0]  saturation;
        int unsigned pixels_seen;
        int unsigned mismatches;

        function new();
            saturation  = SAT_RESET;
            pixels_seen = 0;
            mismatches  = 0;
        endfunction

        function void set_saturation(input logic [7:0] s);
            saturation = s;
        endfunction

        function void note_request(input logic [COORD_BITS-1:0] col,
                                   input logic [COORD_BITS-1:0] row,
                                   input logic [31:0] frame);
            awaited_pixels.push_back(pattern_pixel(col, row, frame, saturation));
        endfunction

        function void check_pixel(input rgb_pixel_t got);
            rgb_pixel_t want;
            pixels_seen++;
            if (awaited_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d arrived with no request outstanding: rgb %h %h %h",
                             pixels_seen, got.red, got.green, got.blue);
                return;
            end
            want = awaited_pixels.pop_front();
            if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: expected rgb %h %h %h, got %h %h %h", pixels_seen,
                             want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction
    endclass

    pixel_tracker tracker;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_saturation(i_cfg_data);
            if (i_valid && !o_stall)
                tracker.note_request(i_pixel_col, i_pixel_row, i_frame_number);
            if (o_valid && !i_stall)
                tracker.check_pixel('{o_red, o_green, o_blue});
        end
    end

    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row,
                              input logic [31:0] frame);
        while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_col    <= col;
        i_pixel_row    <= row;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random_pixel();
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [31:0]           frame;
        int                    kind;
        kind  = $urandom_range(9);
        col   = ($urandom_range(7) == 0) ? {COORD_BITS{$urandom_range(1) == 1}}
                                         : COORD_BITS'($urandom);
        row   = ($urandom_range(7) == 0) ? {COORD_BITS{$urandom_range(1) == 1}}
                                         : COORD_BITS'($urandom);
        if (kind < 4)
            frame = $urandom_range(300);
        else if (kind < 6)
            frame = 32'hFFFF_FFFF - $urandom_range(4095);
        else
            frame = $urandom;
        send_pixel(col, row, frame);
    endtask

    task automatic wait_for_empty();
        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_saturation(input logic [7:0] s);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int         send_plan[4];
        int         recv_plan[4];
        logic [7:0] sat_plan[4];
        tracker        = new();
        send_plan      = '{0, 51, 0, 31};
        recv_plan      = '{0, 0, 51, 31};
        sat_plan       = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_pixel_col    = '0;
        i_pixel_row    = '0;
        i_frame_number = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(12'd0, 12'd0, 32'd0);
        send_pixel(12'd4095, 12'd4095, 32'd0);
        send_pixel(12'd4095, 12'd0, 32'd0);
        send_pixel(12'd0, 12'd4095, 32'd1);
        send_pixel(12'd4095, 12'd4095, 32'd254);
        send_pixel(12'd1, 12'd2, 32'd255);
        send_pixel(12'd2048, 12'd1024, 32'd256);
        send_pixel(12'd4095, 12'd0, 32'hFFFF_FFFF);
        send_pixel(12'd0, 12'd4095, 32'hFFFF_FFFE);
        send_pixel(12'd4095, 12'd4095, 32'h8000_0000);
        send_pixel(12'd2730, 12'd1365, 32'h7FFF_FFFF);
        send_pixel(12'd0, 12'd0, 32'hFFFF_FF01);
        for (int c = 0; c < 10; c++)
            send_pixel(COORD_BITS'(c * 7), 12'd0, 32'd255);

        for (int p = 0; p < 4; p++) begin
            wait_for_empty();
            write_saturation(sat_plan[p]);
            send_idle_pct  = send_plan[p];
            recv_stall_pct = recv_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 1 || p == 3) && n == PHASE_ITEMS / 2)
                    wait_for_empty();
                send_random_pixel();
            end
        end

        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d pixels under five saturation settings and four traffic mixes,",
                 tracker.pixels_seen);
        $display("with %0d pixel errors and %0d requests left unanswered.",
                 tracker.mismatches, tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("hsv_xor_test_pattern_pixel_core_test passed");
        else
            $display("hsv_xor_test_pattern_pixel_core_test failed");
        $finish;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without completing.", cycle_count);
        $display("hsv_xor_test_pattern_pixel_core_test failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/hxp_pkg.sv
hdl/hxp_flow.sv
hdl/hxp_hue_pipe.sv
hdl/hxp_rgb_pipe.sv
hdl/hsv_xor_test_pattern_pixel_core.sv
hdl/hxp_checker.sv
tb/hsv_xor_test_pattern_pixel_core_test.sv
